// ===== design/bad24_pkg.sv =====
`default_nettype none
package bad24_pkg;

  localparam int unsigned FifoDepth = 2;

  // configuration register indexes
  localparam logic CFG_SCSI_MODE = 1'b0;
  localparam logic CFG_EXP_SOUND = 1'b1;

  // access size codes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;

  typedef enum logic [4:0] {
    RG_RAM      = 5'd0,
    RG_GVRAM    = 5'd1,
    RG_TVRAM    = 5'd2,
    RG_CRTC     = 5'd3,
    RG_PAL      = 5'd4,
    RG_VCTRL    = 5'd5,
    RG_DMA      = 5'd6,
    RG_MFP      = 5'd7,
    RG_RTC      = 5'd8,
    RG_SYSPORT  = 5'd9,
    RG_SOUND    = 5'd10,
    RG_ADPCM    = 5'd11,
    RG_FDC      = 5'd12,
    RG_SASI     = 5'd13,
    RG_SCC      = 5'd14,
    RG_PIA      = 5'd15,
    RG_IOC      = 5'd16,
    RG_SCSI     = 5'd17,
    RG_MIDI     = 5'd18,
    RG_BG       = 5'd19,
    RG_EXPSND   = 5'd20,
    RG_SRAM     = 5'd21,
    RG_FONT     = 5'd22,
    RG_IPL      = 5'd23,
    RG_IGN      = 5'd24,
    RG_BERR     = 5'd25,
    RG_SCSIIPL  = 5'd26
  } region_e;

  typedef enum logic [2:0] {
    REQ_CPU_RD = 3'd0,
    REQ_CPU_WR = 3'd1,
    REQ_DMA_RD = 3'd2,
    REQ_DMA_WR = 3'd3,
    REQ_FETCH  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_ADDR_ERR     = 2'd1,
    ST_BUS_ERR      = 2'd2,
    ST_DMA_MISALIGN = 2'd3
  } status_e;

  // what a single-result command does to the sticky flags
  typedef enum logic [1:0] {
    FLG_KEEP  = 2'd0,
    FLG_CLEAR = 2'd1,
    FLG_SET3  = 2'd2,
    FLG_OR4   = 2'd3
  } flg_e;

  typedef enum logic {
    CMD_SINGLE = 1'b0,
    CMD_BYTES  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    region_e     region;     // single result only
    logic [23:0] addr;       // offset for single, base address for bytes
    status_e     status;     // single result only
    flg_e        flg;        // single result only
    logic        wr;
    logic        cpu;
    logic [1:0]  last_lane;
    logic [31:0] wdata;
  } cmd_t;

  typedef struct packed {
    logic scsi_mode;
    logic exp_sound;
  } cfg_t;

  typedef struct packed {
    region_e     region;
    logic [23:0] off;
    logic        is_write;
    logic [7:0]  byte_data;
    logic [1:0]  lane;
    logic        supp;
    logic        last;
    status_e     status;
    logic [2:0]  flags;
  } res_t;

  typedef struct packed {
    region_e     region;
    logic [23:0] off;
  } dec_t;

  // region of the 8 KB I/O pages 0xe80000 .. 0xebffff
  function automatic region_e io_page(logic [4:0] idx);
    region_e r;
    unique case (idx)
      5'd0:    r = RG_CRTC;
      5'd1:    r = RG_PAL;
      5'd2:    r = RG_DMA;
      5'd4:    r = RG_MFP;
      5'd5:    r = RG_RTC;
      5'd7:    r = RG_SYSPORT;
      5'd8:    r = RG_SOUND;
      5'd9:    r = RG_ADPCM;
      5'd10:   r = RG_FDC;
      5'd11:   r = RG_SASI;
      5'd12:   r = RG_SCC;
      5'd13:   r = RG_PIA;
      5'd14:   r = RG_IOC;
      5'd16:   r = RG_SCSI;
      5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22: r = RG_BERR;
      5'd23:   r = RG_MIDI;
      5'd3, 5'd6, 5'd15: r = RG_IGN;
      default: r = RG_BG;
    endcase
    return r;
  endfunction

  // region and offset of one byte of a CPU or DMA access
  function automatic dec_t decode_byte(logic [23:0] a, logic wr, logic scsi, logic exps);
    dec_t    d;
    logic [7:0] p;
    region_e r;
    p = a[20:13];
    d.off = a;
    d.region = RG_IGN;
    r = io_page(p[4:0]);
    if (a < 24'hc00000) begin
      d.region = RG_RAM;
      d.off = {a[23:1], ~a[0]};
    end else if (a < 24'he00000) begin
      d.region = RG_GVRAM;
      d.off = a - 24'hc00000;
    end else if (p < 8'd64) begin
      d.region = RG_TVRAM;
      d.off = a - 24'he00000;
    end else if (p < 8'd96) begin
      if (r == RG_PAL) begin
        if (a < 24'he82400) d.region = RG_PAL;
        else if (a < (wr ? 24'he82700 : 24'he83000)) d.region = RG_VCTRL;
        else d.region = RG_IGN;
      end else if (r == RG_SOUND) begin
        d.region = RG_SOUND;
        // address and data ports on write, status port on read
        if (wr && a[1:0] == 2'd1) d.off = 24'd0;
        else if (wr && a[1:0] == 2'd3) d.off = 24'd1;
        else if (!wr && a[1:0] == 2'd3) d.off = 24'd0;
        else d.region = RG_IGN;
      end else begin
        d.region = r;
      end
    end else if (p < 8'd104) begin
      d.region = (p == 8'd102 && exps) ? RG_EXPSND : RG_BERR;
    end else if (p < 8'd112) begin
      d.region = RG_SRAM;
    end else if (wr || p < 8'd128) begin
      d.region = RG_BERR;
    end else if (p < 8'd224) begin
      d.region = RG_FONT;
      d.off = {4'd0, a[19:0]};
    end else if (scsi && p < 8'd240) begin
      d.region = RG_BERR;
    end else begin
      d.region = RG_IPL;
      d.off = {6'd0, a[17:1], ~a[0]};
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== design/bad24_front.sv =====
`default_nettype none
module bad24_front
  import bad24_pkg::*;
(
  input  wire logic [2:0]  req_type_i,
  input  wire logic [23:0] address_i,
  input  wire logic [1:0]  access_size_i,
  input  wire logic [31:0] write_data_i,
  output cmd_t             cmd_o
);

  logic misaligned;
  logic is_long;
  dec_t fetch;

  assign is_long    = access_size_i != SZ_BYTE && access_size_i != SZ_WORD;
  assign misaligned = access_size_i != SZ_BYTE && address_i[0];

  // instruction-fetch base lookup
  always_comb begin
    fetch.region = RG_BERR;
    fetch.off    = address_i;
    if (address_i[23:20] < 4'hc) begin
      fetch.region = RG_RAM;
    end else if (address_i[23:20] < 4'he) begin
      fetch.region = RG_GVRAM;
      fetch.off    = address_i - 24'hc00000;
    end else if (address_i[23:20] == 4'he) begin
      if (address_i < 24'he80000) begin
        fetch.region = RG_TVRAM;
        fetch.off    = address_i - 24'he00000;
      end else if (address_i >= 24'hea0000 && address_i < 24'hea2000) begin
        fetch.region = RG_SCSIIPL;
        fetch.off    = address_i - 24'hea0000;
      end else if (address_i >= 24'hed0000 && address_i < 24'hed4000) begin
        fetch.region = RG_SRAM;
        fetch.off    = address_i - 24'hed0000;
      end
    end else if (address_i >= 24'hfe0000) begin
      fetch.region = RG_IPL;
      fetch.off    = address_i - 24'hfe0000;
    end
  end

  always_comb begin
    cmd_o.kind      = CMD_SINGLE;
    cmd_o.region    = RG_IGN;
    cmd_o.addr      = address_i;
    cmd_o.status    = ST_OK;
    cmd_o.flg       = FLG_KEEP;
    cmd_o.wr        = 1'b0;
    cmd_o.cpu       = 1'b0;
    cmd_o.last_lane = 2'd0;
    cmd_o.wdata     = write_data_i;
    unique case (req_type_i) inside
      REQ_FETCH: begin
        cmd_o.region = fetch.region;
        cmd_o.addr   = fetch.off;
        if (fetch.region == RG_BERR) begin
          cmd_o.flg    = FLG_SET3;
          cmd_o.status = ST_BUS_ERR;
        end
      end
      REQ_CPU_RD, REQ_CPU_WR, REQ_DMA_RD, REQ_DMA_WR: begin
        if (misaligned) begin
          if (!req_type_i[1]) begin
            cmd_o.status = ST_ADDR_ERR;
            cmd_o.flg    = (!req_type_i[0] && is_long) ? FLG_CLEAR : FLG_KEEP;
          end else begin
            cmd_o.status = ST_DMA_MISALIGN;
            cmd_o.flg    = req_type_i[0] ? FLG_OR4 : FLG_SET3;
          end
        end else begin
          cmd_o.kind      = CMD_BYTES;
          cmd_o.wr        = req_type_i[0];
          cmd_o.cpu       = !req_type_i[1];
          cmd_o.last_lane = (access_size_i == SZ_BYTE) ? 2'd0 :
                            (access_size_i == SZ_WORD) ? 2'd1 : 2'd3;
        end
      end
      default: begin
        // unknown request: one status-only transfer, no effect
        cmd_o.kind = CMD_SINGLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/bad24_fifo.sv =====
`default_nettype none
module bad24_fifo
  import bad24_pkg::*;
#(
  parameter int unsigned Depth = FifoDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule
`default_nettype wire

// ===== design/bad24_back.sv =====
`default_nettype none
module bad24_back
  import bad24_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire cmd_t head_i,
  input  wire logic head_valid_i,
  output logic      pop_o,
  output res_t      res_o,
  output logic      res_valid_o,
  input  wire logic res_ready_i
);

  logic        out_valid_q, out_valid_d;
  res_t        out_q, res_d;
  logic [1:0]  lane_q, lane_d;
  logic [2:0]  flags_q, flags_d, flags_cur;
  logic [23:0] byte_addr;
  logic [1:0]  byte_idx;
  logic        advance, emit, raise;
  dec_t        dec;

  assign advance   = !out_valid_q || res_ready_i;
  assign emit      = head_valid_i && advance;
  assign byte_addr = head_i.addr + {22'd0, lane_q};
  assign byte_idx  = head_i.last_lane - lane_q;
  assign dec       = decode_byte(byte_addr, head_i.wr, cfg_i.scsi_mode, cfg_i.exp_sound);
  // a CPU access clears the flags before its first byte
  assign flags_cur = (head_i.cpu && lane_q == 2'd0) ? 3'd0 : flags_q;

  always_comb begin
    res_d.region    = head_i.region;
    res_d.off       = head_i.addr;
    res_d.is_write  = 1'b0;
    res_d.byte_data = 8'd0;
    res_d.lane      = 2'd0;
    res_d.supp      = 1'b0;
    res_d.last      = 1'b1;
    res_d.status    = head_i.status;
    flags_d         = flags_q;
    raise           = 1'b0;
    case (head_i.kind)
      CMD_SINGLE: begin
        case (head_i.flg)
          FLG_CLEAR: flags_d = 3'd0;
          FLG_SET3:  flags_d = 3'd3;
          FLG_OR4:   flags_d = flags_q | 3'd4;
          default:   flags_d = flags_q;
        endcase
      end
      default: begin
        res_d.region = dec.region;
        res_d.off    = dec.off;
        res_d.lane   = lane_q;
        res_d.last   = lane_q == head_i.last_lane;
        flags_d      = flags_cur;
        if (head_i.wr) begin
          res_d.is_write  = 1'b1;
          res_d.byte_data = head_i.wdata[{byte_idx, 3'b000} +: 8];
          // drop write bytes while an earlier error is pending
          if (flags_cur != 3'd0) res_d.supp = 1'b1;
          else if (dec.region == RG_BERR) flags_d = 3'd2;
        end else if (dec.region == RG_BERR) begin
          flags_d = 3'd1;
        end
        if (head_i.cpu) begin
          raise = head_i.wr ? flags_d[1] : (head_i.last_lane <= 2'd1 && flags_d[0]);
        end
        res_d.status = (res_d.last && raise) ? ST_BUS_ERR : ST_OK;
      end
    endcase
    res_d.flags = flags_d;
  end

  always_comb begin
    lane_d      = lane_q;
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = head_valid_i;
    if (emit) lane_d = res_d.last ? 2'd0 : lane_q + 2'd1;
  end

  assign pop_o       = emit && res_d.last;
  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      lane_q      <= 2'd0;
      flags_q     <= 3'd0;
    end else begin
      out_valid_q <= out_valid_d;
      lane_q      <= lane_d;
      if (emit) flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= res_d;
  end

endmodule
`default_nettype wire

// ===== design/bus_address_decoder_24bit.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: address, access_size, write_data
//                                              tuser: req_type
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: region .. error_flags, tuser: is_write
//                                              tlast: last result of an access
// cfg       in   cfg_we_i                      cfg_idx_i, cfg_wdata_i
//
// One result per cycle when not stalled: a byte access gives one result, a word two, a long
// four, and a fetch, misaligned or unknown request one; the back-end lane sequencer sets this.
// The front end classifies in the accept cycle and queues the command (2 deep).
// Reset clears the sticky error flags and the queue; scsi_mode resets to 0,
// expansion_sound_present to 1. A stalled output holds in the output register
// while the queue keeps taking new transfers until it fills.
`default_nettype none
module bus_address_decoder_24bit
  import bad24_pkg::*;
#(
  parameter int unsigned QueueDepth = FifoDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [23:0] address, [25:24] access_size, [57:26] write_data
  input  wire logic [63:0] s_axis_tdata,
  // [2:0] req_type
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [4:0] region, [28:5] local_offset, [36:29] byte_data, [38:37] byte_lane,
  // [39] suppressed, [41:40] status, [44:42] error_flags
  output logic [47:0]      m_axis_tdata,
  // [0] is_write
  output logic             m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic        cfg_wdata_i
);

  cfg_t cfg_q;
  cmd_t front_cmd, head_cmd;
  res_t res;
  logic full, empty, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scsi_mode <= 1'b0;
      cfg_q.exp_sound <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SCSI_MODE) cfg_q.scsi_mode <= cfg_wdata_i;
      if (cfg_idx_i == CFG_EXP_SOUND) cfg_q.exp_sound <= cfg_wdata_i;
    end
  end

  bad24_front u_front (
    .req_type_i    (s_axis_tuser),
    .address_i     (s_axis_tdata[23:0]),
    .access_size_i (s_axis_tdata[25:24]),
    .write_data_i  (s_axis_tdata[57:26]),
    .cmd_o         (front_cmd)
  );

  bad24_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .empty_o (empty)
  );

  assign s_axis_tready = !full;

  bad24_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head_cmd),
    .head_valid_i (!empty),
    .pop_o        (pop),
    .res_o        (res),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {3'd0, res.flags, res.status, res.supp, res.lane,
                         res.byte_data, res.off, res.region};
  assign m_axis_tuser = res.is_write;
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top
  import bad24_pkg::*;
;

  localparam int          CycleLimit = 200000;
  localparam int          PhaseItems = 110;
  localparam int          HoldCycles = 80;
  localparam logic [1:0]  SzLong     = 2'd2;
  localparam logic [1:0]  SzOdd      = 2'd3;  // size code 3, behaves as long
  localparam logic [2:0]  ReqUnused  = 3'd7;

  typedef struct packed {
    region_e     region;
    logic [23:0] off;
    logic        wr;
    logic [7:0]  data;
    logic [1:0]  lane;
    logic        supp;
    logic        last;
    status_e     status;
    logic [2:0]  flags;
  } lane_res_t;

  typedef struct packed {
    logic [2:0]  req;
    logic [23:0] addr;
    logic [1:0]  sz;
    logic [31:0] wd;
    logic        pin;
    region_e     region;
    logic [23:0] off;
    status_e     status;
  } probe_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;

  // decoder mirror
  logic [2:0]  flag_bits = '0;
  logic [23:0] err_addr = '0;
  logic        berr_seen = 1'b0;
  logic        cfg_scsi = 1'b0;
  logic        cfg_exps = 1'b1;
  lane_res_t   lane_q[$];

  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  int n_items = 0;
  int n_results = 0;
  int n_fail = 0;
  int cycles = 0;
  lane_res_t got;

  probe_t probes [25] = '{
    '{REQ_CPU_RD, 24'h000000, SZ_BYTE, 32'h0, 1'b1, RG_RAM, 24'h000001, ST_OK},
    '{REQ_CPU_RD, 24'hffffff, SZ_BYTE, 32'h0, 1'b1, RG_IPL, 24'h03fffe, ST_OK},
    '{REQ_CPU_WR, 24'h000000, SzLong, 32'hdeadbeef, 1'b0, RG_IGN, 24'h0, ST_OK},
    '{REQ_CPU_RD, 24'h000001, SZ_WORD, 32'h0, 1'b1, RG_IGN, 24'h000001, ST_ADDR_ERR},
    '{REQ_CPU_RD, 24'h000003, SzLong, 32'h0, 1'b1, RG_IGN, 24'h000003, ST_ADDR_ERR},
    '{REQ_CPU_RD, 24'hee0000, SZ_BYTE, 32'h0, 1'b1, RG_BERR, 24'hee0000, ST_BUS_ERR},
    '{REQ_CPU_WR, 24'he82000, SZ_WORD, 32'h0000a55a, 1'b0, RG_IGN, 24'h0, ST_OK},
    '{REQ_DMA_RD, 24'h123457, SZ_WORD, 32'h0, 1'b1, RG_IGN, 24'h123457, ST_DMA_MISALIGN},
    '{REQ_DMA_WR, 24'he90000, SzLong, 32'h01234567, 1'b0, RG_IGN, 24'h0, ST_OK},
    '{REQ_CPU_WR, 24'he82400, SzLong, 32'h89abcdef, 1'b0, RG_IGN, 24'h0, ST_OK},
    '{REQ_DMA_WR, 24'he90000, SzLong, 32'hfedcba98, 1'b0, RG_IGN, 24'h0, ST_OK},
    '{REQ_CPU_RD, 24'he82ffe, SzLong, 32'h0, 1'b0, RG_IGN, 24'h0, ST_OK},
    '{REQ_CPU_WR, 24'heffffe, SzLong, 32'h11223344, 1'b0, RG_IGN, 24'h0, ST_OK},
    '{REQ_DMA_WR, 24'h000003, SZ_WORD, 32'h0, 1'b1, RG_IGN, 24'h000003, ST_DMA_MISALIGN},
    '{REQ_FETCH, 24'h000000, SZ_BYTE, 32'h0, 1'b1, RG_RAM, 24'h000000, ST_OK},
    '{REQ_FETCH, 24'hea0010, SzLong, 32'h0, 1'b1, RG_SCSIIPL, 24'h000010, ST_OK},
    '{REQ_FETCH, 24'hed3fff, SZ_WORD, 32'h0, 1'b1, RG_SRAM, 24'h003fff, ST_OK},
    '{REQ_FETCH, 24'hfe1234, SzOdd, 32'hffffffff, 1'b1, RG_IPL, 24'h001234, ST_OK},
    '{REQ_FETCH, 24'he80000, SZ_BYTE, 32'h0, 1'b1, RG_BERR, 24'he80000, ST_BUS_ERR},
    '{ReqUnused, 24'habcdef, SZ_BYTE, 32'h0, 1'b1, RG_IGN, 24'habcdef, ST_OK},
    '{REQ_CPU_RD, 24'hfffffe, SzOdd, 32'h0, 1'b0, RG_IGN, 24'h0, ST_OK},
    '{REQ_DMA_RD, 24'hecc000, SzLong, 32'h0, 1'b0, RG_IGN, 24'h0, ST_OK},
    '{REQ_CPU_RD, 24'hc00000, SzLong, 32'h0, 1'b0, RG_IGN, 24'h0, ST_OK},
    '{REQ_CPU_RD, 24'hf00000, SZ_WORD, 32'h0, 1'b0, RG_IGN, 24'h0, ST_OK},
    '{REQ_CPU_WR, 24'hed0000, SZ_BYTE, 32'hffffffff, 1'b0, RG_IGN, 24'h0, ST_OK}
  };

  bus_address_decoder_24bit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // target of one byte of a CPU or DMA access
  function automatic void byte_target(input logic [23:0] a, input logic wr,
                                      output region_e r, output logic [23:0] off);
    logic [7:0] pg;
    pg = a[20:13];
    off = a;
    r = RG_IGN;
    if (a < 24'hc00000) begin
      r = RG_RAM;
      off = a ^ 24'd1;
    end else if (a < 24'he00000) begin
      r = RG_GVRAM;
      off = a - 24'hc00000;
    end else if (pg < 8'd64) begin
      r = RG_TVRAM;
      off = a - 24'he00000;
    end else if (pg < 8'd96) begin
      case (a[17:13])
        5'd0: r = RG_CRTC;
        5'd1: begin
          if (a < 24'he82400) r = RG_PAL;
          else if (a < (wr ? 24'he82700 : 24'he83000)) r = RG_VCTRL;
          else r = RG_IGN;
        end
        5'd2: r = RG_DMA;
        5'd4: r = RG_MFP;
        5'd5: r = RG_RTC;
        5'd7: r = RG_SYSPORT;
        5'd8: begin
          // address port on writes at 1, data or status port at 3
          if (wr && a[1:0] == 2'd1) begin
            r = RG_SOUND;
            off = 24'd0;
          end else if (a[1:0] == 2'd3) begin
            r = RG_SOUND;
            off = {23'd0, wr};
          end
        end
        5'd9: r = RG_ADPCM;
        5'd10: r = RG_FDC;
        5'd11: r = RG_SASI;
        5'd12: r = RG_SCC;
        5'd13: r = RG_PIA;
        5'd14: r = RG_IOC;
        5'd16: r = RG_SCSI;
        5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22: r = RG_BERR;
        5'd23: r = RG_MIDI;
        5'd3, 5'd6, 5'd15: r = RG_IGN;
        default: r = RG_BG;
      endcase
    end else if (pg < 8'd104) begin
      if (pg == 8'd102 && cfg_exps) r = RG_EXPSND;
      else r = RG_BERR;
    end else if (pg < 8'd112) begin
      r = RG_SRAM;
    end else if (wr || pg < 8'd128) begin
      r = RG_BERR;
    end else if (pg < 8'd224) begin
      r = RG_FONT;
      off = {4'd0, a[19:0]};
    end else if (cfg_scsi && pg < 8'd240) begin
      r = RG_BERR;
    end else begin
      r = RG_IPL;
      off = {6'd0, a[17:0]} ^ 24'd1;
    end
  endfunction

  function automatic void queue_lane(input region_e r, input logic [23:0] off, input logic wr,
                                     input logic [7:0] data, input logic [1:0] lane,
                                     input logic supp);
    lane_res_t e;
    e.region = r;
    e.off = off;
    e.wr = wr;
    e.data = data;
    e.lane = lane;
    e.supp = supp;
    e.last = 1'b0;
    e.status = ST_OK;
    e.flags = flag_bits;
    lane_q.push_back(e);
  endfunction

  // expected byte results of one accepted access; updates the sticky flags
  function automatic void decode_access(input logic [2:0] req, input logic [23:0] addr,
                                        input logic [1:0] sz, input logic [31:0] wd);
    int          n;
    int          i;
    status_e     st;
    region_e     r;
    logic [23:0] off;
    logic [23:0] a;
    logic [7:0]  b;
    logic        cpu;
    logic        wr;
    n = (sz == SZ_BYTE) ? 1 : (sz == SZ_WORD) ? 2 : 4;
    st = ST_OK;
    cpu = !req[1];
    wr = req[0];
    if (req == REQ_FETCH) begin
      r = RG_BERR;
      off = addr;
      if (addr < 24'hc00000) begin
        r = RG_RAM;
      end else if (addr < 24'he00000) begin
        r = RG_GVRAM;
        off = addr - 24'hc00000;
      end else if (addr < 24'he80000) begin
        r = RG_TVRAM;
        off = addr - 24'he00000;
      end else if (addr >= 24'hea0000 && addr < 24'hea2000) begin
        r = RG_SCSIIPL;
        off = addr - 24'hea0000;
      end else if (addr >= 24'hed0000 && addr < 24'hed4000) begin
        r = RG_SRAM;
        off = addr - 24'hed0000;
      end else if (addr >= 24'hfe0000) begin
        r = RG_IPL;
        off = addr - 24'hfe0000;
      end
      if (r == RG_BERR) begin
        flag_bits = 3'd3;
        err_addr = addr;
        berr_seen = 1'b1;
        st = ST_BUS_ERR;
      end
      queue_lane(r, off, 1'b0, 8'd0, 2'd0, 1'b0);
    end else if (req < REQ_FETCH) begin
      if (n > 1 && addr[0]) begin
        if (cpu) begin
          st = ST_ADDR_ERR;
          if (!wr && n == 4) flag_bits = 3'd0;
        end else begin
          st = ST_DMA_MISALIGN;
          if (wr) flag_bits = flag_bits | 3'd4;
          else flag_bits = 3'd3;
        end
        queue_lane(RG_IGN, addr, 1'b0, 8'd0, 2'd0, 1'b0);
      end else begin
        if (cpu) flag_bits = 3'd0;
        for (i = 0; i < n; i++) begin
          a = addr + 24'(i);
          b = 8'(wd >> (8 * (n - 1 - i)));
          byte_target(a, wr, r, off);
          if (wr && flag_bits != 3'd0) begin
            queue_lane(r, off, 1'b1, b, 2'(i), 1'b1);
          end else begin
            if (r == RG_BERR) begin
              flag_bits = wr ? 3'd2 : 3'd1;
              err_addr = a;
            end
            queue_lane(r, off, wr, wr ? b : 8'd0, 2'(i), 1'b0);
          end
        end
        // long CPU reads set the flag but raise nothing
        if (cpu && (wr ? flag_bits[1] : (n <= 2 && flag_bits[0]))) begin
          berr_seen = 1'b1;
          st = ST_BUS_ERR;
        end
      end
    end else begin
      queue_lane(RG_IGN, addr, 1'b0, 8'd0, 2'd0, 1'b0);
    end
    lane_q[lane_q.size() - 1].last = 1'b1;
    lane_q[lane_q.size() - 1].status = st;
  endfunction

  function automatic logic [23:0] pick_addr();
    case ($urandom_range(13))
      0: return 24'($urandom_range(24'hbfffff));
      1: return 24'hc00000 + 24'($urandom_range(24'h1fffff));
      2: return 24'he00000 + 24'($urandom_range(24'h7ffff));
      3: return 24'he80000 + 24'($urandom_range(24'h3ffff));
      4: return 24'he82000 + 24'($urandom_range(24'h1fff));
      5: return 24'he90000 + 24'($urandom_range(24'h1fff));
      6: return 24'hec0000 + 24'($urandom_range(24'hffff));
      7: return 24'hed0000 + 24'($urandom_range(24'hffff));
      8: return 24'hee0000 + 24'($urandom_range(24'h1ffff));
      9: return 24'hf00000 + 24'($urandom_range(24'hbffff));
      10: return 24'hfc0000 + 24'($urandom_range(24'h3ffff));
      11: return 24'hfffff8 + 24'($urandom_range(7));
      12: return 24'hea0000 + 24'($urandom_range(24'h3fff));
      default: return 24'($urandom);
    endcase
  endfunction

  // offer one access and hold until the transfer completes
  task automatic offer(input logic [2:0] req, input logic [23:0] addr, input logic [1:0] sz,
                       input logic [31:0] wd, input logic pin, input region_e preg,
                       input logic [23:0] poff, input status_e pst);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {6'd0, wd, sz, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    decode_access(req, addr, sz, wd);
    if (pin) begin
      lane_q[lane_q.size() - 1].region = preg;
      lane_q[lane_q.size() - 1].off = poff;
      lane_q[lane_q.size() - 1].status = pst;
    end
    n_items++;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic random_item();
    int          pick;
    logic [2:0]  req;
    pick = $urandom_range(99);
    if (pick < 25) req = REQ_CPU_RD;
    else if (pick < 50) req = REQ_CPU_WR;
    else if (pick < 65) req = REQ_DMA_RD;
    else if (pick < 80) req = REQ_DMA_WR;
    else if (pick < 95) req = REQ_FETCH;
    else req = 3'($urandom_range(7, 5));
    offer(req, pick_addr(), 2'($urandom_range(3)), $urandom, 1'b0, RG_IGN, 24'd0, ST_OK);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (lane_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic scsi, input logic exps);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_SCSI_MODE;
    cfg_wdata_i <= scsi;
    @(posedge clk_i);
    cfg_idx_i <= CFG_EXP_SOUND;
    cfg_wdata_i <= exps;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_scsi = scsi;
    cfg_exps = exps;
  endtask

  task automatic check_lane(input lane_res_t g);
    lane_res_t want;
    string     bad;
    n_results++;
    if (lane_q.size() == 0) begin
      n_fail++;
      if (n_fail <= 10) $display("ERROR: result with nothing expected: %h", g);
      return;
    end
    want = lane_q.pop_front();
    bad = "";
    if (g.region !== want.region) bad = {bad, " region"};
    if (g.off !== want.off) bad = {bad, " offset"};
    if (g.wr !== want.wr) bad = {bad, " is_write"};
    if (g.data !== want.data) bad = {bad, " byte_data"};
    if (g.lane !== want.lane) bad = {bad, " lane"};
    if (g.supp !== want.supp) bad = {bad, " suppressed"};
    if (g.last !== want.last) bad = {bad, " last"};
    if (g.status !== want.status) bad = {bad, " status"};
    if (g.flags !== want.flags) bad = {bad, " flags"};
    if (bad != "") begin
      n_fail++;
      if (n_fail <= 10)
        $display("ERROR: mismatch in%s: exp rg=%0d off=%h wr=%b d=%h ln=%0d sp=%b l=%b st=%0d fl=%h,",
                 bad, want.region, want.off, want.wr, want.data, want.lane, want.supp,
                 want.last, want.status, want.flags,
                 " got rg=%0d off=%h wr=%b d=%h ln=%0d sp=%b l=%b st=%0d fl=%h",
                 g.region, g.off, g.wr, g.data, g.lane, g.supp, g.last, g.status, g.flags);
    end
  endtask

  // result side: check each transfer, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.region = region_e'(m_axis_tdata[4:0]);
      got.off = m_axis_tdata[28:5];
      got.data = m_axis_tdata[36:29];
      got.lane = m_axis_tdata[38:37];
      got.supp = m_axis_tdata[39];
      got.status = status_e'(m_axis_tdata[41:40]);
      got.flags = m_axis_tdata[44:42];
      got.wr = m_axis_tuser;
      got.last = m_axis_tlast;
      check_lane(got);
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, lane_q.size());
      $display("bus_address_decoder_24bit test failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 35;
    recv_idle = 79;
    set_config(1'b0, 1'b1);
    for (int k = 0; k < 25; k++)
      offer(probes[k].req, probes[k].addr, probes[k].sz, probes[k].wd, probes[k].pin,
            probes[k].region, probes[k].off, probes[k].status);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin
          send_idle = 79;
          recv_idle = 35;
          set_config(1'b1, 1'b0);
        end
        2: begin
          send_idle = 0;
          recv_idle = 0;
          set_config(1'b1, 1'b1);
        end
        3: set_config(1'b0, 1'b0);
        default: ;
      endcase
      for (int k = 0; k < PhaseItems; k++) begin
        // pause the sender until every result is back
        if (ph == 1 && k == 50) drain();
        // stall the result side while the sender keeps offering
        if (ph == 2 && k == 20) hold_req = 1'b1;
        random_item();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Summary: %0d accesses, %0d byte results checked under four register settings,",
             n_items, n_results);
    $display("  with directed corners, fetch lookups, faults, and stalls on both sides");
    if (n_fail == 0 && lane_q.size() == 0) begin
      $display("bus_address_decoder_24bit test passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_fail, lane_q.size());
      $display("bus_address_decoder_24bit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bad24_pkg.sv
design/bad24_front.sv
design/bad24_fifo.sv
design/bad24_back.sv
design/bus_address_decoder_24bit.sv
tb/tb_top.sv
